/* design/esma_pkg.sv */
// shared types and constants for the event slot map allocator
// no dependencies; imported by every module of the block
package esma_pkg;

	// table geometry
	localparam int SLOT_COUNT      = 256;
	localparam int SLOT_W          = $clog2(SLOT_COUNT);
	localparam int PRIM_INDEX_BITS = 6;
	localparam int CELL_INDEX_BITS = 16;
	localparam int ID_W            = PRIM_INDEX_BITS + CELL_INDEX_BITS;

	// port field widths
	localparam int MODE_W     = 2;
	localparam int PRIM_W     = 6;
	localparam int CELL_W     = 16;
	localparam int SIDX_W     = 8;
	localparam int SLOT_OUT_W = 8;
	localparam int STATUS_W   = 3;

	// request modes, any other code reads a slot
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 3'd0,
		ST_ASSIGNED = 3'd1,
		ST_NOSPACE  = 3'd2,
		ST_FREED    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_DRAIN,
		S_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic read_one;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last_issue;
		logic out_free;
	} dp_stat_t;

endpackage

/* design/event_slot_map_allocator.sv */
// top level of the event slot map allocator
// depends on esma_pkg, esma_ctrl and esma_datapath
//
// A table of SLOT_COUNT slots, each free or holding one identifier (event type index and
// cell index). Mode 0 looks an identifier up and returns its slot, or takes the lowest free
// slot and reports a new assignment, or reports no space and raises the sticky
// rebuild_needed flag (cleared only by reset). Mode 1 frees the slot holding an identifier,
// mode 2 (and 3) reads back what a slot stores. One request is worked on at a time. Lookup
// and free walk the identifier memory one slot per clock through its single read port until
// the identifier is found or the last slot is issued, then drain the read pipe; a slot read
// reads just that one slot. The result register loads at the commit that follows, and the
// next request is taken after that commit. The result sits in an output register, so a new
// request is taken while the previous result waits on out_stall; only the commit of the
// following result waits for it. The valid bits are cleared by reset; there is no clearing pass.
module event_slot_map_allocator import esma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [PRIM_W-1:0]     event_prim_index,
	input  logic [CELL_W-1:0]     event_unitcell_index,
	input  logic [SIDX_W-1:0]     slot_index,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_OUT_W-1:0] slot_out,
	output logic [PRIM_W-1:0]     out_prim_index,
	output logic [CELL_W-1:0]     out_unitcell_index,
	output logic                  slot_in_use,
	output logic                  rebuild_needed
);

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: idle, scan or single read, drain of the read pipe after a scan, commit
	esma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table storage, compare stage and result register
	esma_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.mode                 (mode),
		.event_prim_index     (event_prim_index),
		.event_unitcell_index (event_unitcell_index),
		.slot_index           (slot_index),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.status               (status),
		.slot_out             (slot_out),
		.out_prim_index       (out_prim_index),
		.out_unitcell_index   (out_unitcell_index),
		.slot_in_use          (slot_in_use),
		.rebuild_needed       (rebuild_needed)
	);

endmodule

/* design/esma_ctrl.sv */
// sequencing state machine of the event slot map allocator
// depends on esma_pkg; drives commands into esma_datapath
module esma_ctrl import esma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode inside {MODE_LOOKUP, MODE_FREE}) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_SCAN: begin
				if (stat.hit || stat.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_READ:  state_d = S_COMMIT;
			S_DRAIN: state_d = S_COMMIT;
			S_COMMIT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_SCAN:   cmd.issue    = 1'b1;
			S_READ:   cmd.read_one = 1'b1;
			S_DRAIN:  cmd          = '0;
			S_COMMIT: cmd.commit   = stat.out_free;
			default:  cmd          = '0;
		endcase
	end

endmodule

/* design/esma_datapath.sv */
// identifier memory, valid bits, scan compare and result register
// depends on esma_pkg; controlled by esma_ctrl
module esma_datapath import esma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [MODE_W-1:0]     mode,
	input  logic [PRIM_W-1:0]     event_prim_index,
	input  logic [CELL_W-1:0]     event_unitcell_index,
	input  logic [SIDX_W-1:0]     slot_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_OUT_W-1:0] slot_out,
	output logic [PRIM_W-1:0]     out_prim_index,
	output logic [CELL_W-1:0]     out_unitcell_index,
	output logic                  slot_in_use,
	output logic                  rebuild_needed
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

	logic [ID_W-1:0]       id_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;

	// request registers
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   key_q;
	logic [SLOT_W-1:0] sidx_q;
	logic              in_range_q;

	// scan state
	logic [SLOT_W-1:0] scan_cnt_q;
	logic [ID_W-1:0]   rd_data_s1;
	logic              valid_s1;
	logic [SLOT_W-1:0] addr_s1;
	logic              chk_s1;
	logic              found_q;
	logic [SLOT_W-1:0] hit_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_q;
	logic              rebuild_q;

	// result register
	logic                  out_valid_q;
	status_t               status_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic [PRIM_W-1:0]     prim_q;
	logic [CELL_W-1:0]     cell_q;
	logic                  in_use_q;
	logic                  rebuild_out_q;

	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic              match_now;
	logic              wr_en;
	logic              clr_en;
	logic              set_rebuild;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	logic              res_slot_ok;

	assign rd_en     = cmd.issue | cmd.read_one;
	assign rd_addr   = cmd.read_one ? sidx_q : scan_cnt_q;
	assign match_now = chk_s1 & valid_s1 & (rd_data_s1 == key_q);

	assign stat.hit        = match_now | found_q;
	assign stat.last_issue = (scan_cnt_q == LAST_SLOT);
	assign stat.out_free   = ~out_valid_q | ~out_stall;

	// outcome of the finished request
	always_comb begin
		res_status  = ST_READ;
		res_slot    = '0;
		res_slot_ok = 1'b0;
		wr_en       = 1'b0;
		clr_en      = 1'b0;
		set_rebuild = 1'b0;
		case (mode_q)
			MODE_LOOKUP: begin
				if (found_q) begin
					res_status  = ST_FOUND;
					res_slot    = hit_q;
					res_slot_ok = 1'b1;
				end else if (free_found_q) begin
					res_status  = ST_ASSIGNED;
					res_slot    = free_q;
					res_slot_ok = 1'b1;
					wr_en       = cmd.commit;
				end else begin
					res_status  = ST_NOSPACE;
					set_rebuild = cmd.commit;
				end
			end
			MODE_FREE: begin
				if (found_q) begin
					res_status  = ST_FREED;
					res_slot    = hit_q;
					res_slot_ok = 1'b1;
					clr_en      = cmd.commit;
				end else begin
					res_status  = ST_NOTFOUND;
				end
			end
			default: res_status = ST_READ;
		endcase
	end

	// identifier memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[free_q] <= key_q;
		end
		if (rd_en) begin
			rd_data_s1 <= id_mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= mode;
			key_q      <= {PRIM_INDEX_BITS'(event_prim_index),
				CELL_INDEX_BITS'(event_unitcell_index)};
			sidx_q     <= SLOT_W'(slot_index);
			in_range_q <= (32'(slot_index) < 32'(SLOT_COUNT));
		end
		if (rd_en) begin
			valid_s1 <= valid_q[rd_addr];
			addr_s1  <= rd_addr;
		end
		if (match_now && !found_q) begin
			hit_q <= addr_s1;
		end
		if (chk_s1 && !valid_s1 && !free_found_q) begin
			free_q <= addr_s1;
		end
		if (cmd.commit) begin
			status_q      <= res_status;
			slot_out_q    <= res_slot_ok ? SLOT_OUT_W'(res_slot) : '0;
			prim_q        <= '0;
			cell_q        <= '0;
			in_use_q      <= 1'b0;
			rebuild_out_q <= rebuild_q | set_rebuild;
			if (res_status == ST_READ && in_range_q) begin
				prim_q   <= PRIM_W'(rd_data_s1[ID_W-1 -: PRIM_INDEX_BITS]);
				cell_q   <= CELL_W'(rd_data_s1[CELL_INDEX_BITS-1:0]);
				in_use_q <= valid_s1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			scan_cnt_q   <= '0;
			chk_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			rebuild_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			chk_s1 <= cmd.issue;
			if (cmd.load) begin
				scan_cnt_q   <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				if (match_now) begin
					found_q <= 1'b1;
				end
				if (chk_s1 && !valid_s1) begin
					free_found_q <= 1'b1;
				end
			end
			if (wr_en) begin
				valid_q[free_q] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[hit_q] <= 1'b0;
			end
			if (set_rebuild) begin
				rebuild_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign slot_out           = slot_out_q;
	assign out_prim_index     = prim_q;
	assign out_unitcell_index = cell_q;
	assign slot_in_use        = in_use_q;
	assign rebuild_needed     = rebuild_out_q;

endmodule

/* design/esma_checker.sv */
// port level checks of the event slot map allocator
// depends on esma_pkg; bound to event_slot_map_allocator
module esma_checker import esma_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [MODE_W-1:0]     mode,
	input logic [PRIM_W-1:0]     event_prim_index,
	input logic [CELL_W-1:0]     event_unitcell_index,
	input logic [SIDX_W-1:0]     slot_index,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [STATUS_W-1:0]   status,
	input logic [SLOT_OUT_W-1:0] slot_out,
	input logic [PRIM_W-1:0]     out_prim_index,
	input logic [CELL_W-1:0]     out_unitcell_index,
	input logic                  slot_in_use,
	input logic                  rebuild_needed
);

	// a result with the flag set has been seen
	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && rebuild_needed) begin
			seen_q <= 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(mode) && $stable(event_prim_index)
			&& $stable(event_unitcell_index) && $stable(slot_index))
		else $error("request dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_out)
			&& $stable(out_prim_index) && $stable(out_unitcell_index)
			&& $stable(slot_in_use) && $stable(rebuild_needed))
		else $error("result dropped or changed while stalled");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> rebuild_needed)
		else $error("rebuild flag cleared without reset");

	a_nospace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOSPACE |-> rebuild_needed && slot_out == '0)
		else $error("no space result without rebuild flag");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_READ |-> out_prim_index == '0
			&& out_unitcell_index == '0 && !slot_in_use)
		else $error("slot contents shown outside a slot read");

endmodule

bind event_slot_map_allocator esma_checker u_esma_checker (.*);
